[rtl/core/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, case codes and payload types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ROOT_W     = 48;
    localparam int MAG_W      = 32;
    localparam int PROD_W     = 64;
    localparam int DISC_W     = 66;
    localparam int SQRT_W     = DISC_W / 2;
    localparam int DIV1_NUM_W = 64;
    localparam int DIV1_DEN_W = 32;
    localparam int DIV2_NUM_W = 50;
    localparam int DIV2_DEN_W = 34;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] STATUS_REAL    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COMPLEX = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

    localparam logic [ROOT_W-1:0] ROOT_POS_MAG = {1'b0, {(ROOT_W-1){1'b1}}};
    localparam logic [ROOT_W-1:0] ROOT_NEG_MAG = {1'b1, {(ROOT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CASE_FAIL,
        CASE_LINEAR,
        CASE_ZERO,
        CASE_SQRT,
        CASE_GENERAL,
        CASE_DPOS,
        CASE_DZERO,
        CASE_DNEG
    } case_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root_first;
        logic signed [ROOT_W-1:0] root_second;
        logic [STATUS_W-1:0]      root_status;
        logic                     saturated;
    } qrs_out_t;

    typedef struct packed {
        case_t            kind;
        logic             sa;
        logic             sb;
        logic             sc;
        logic [MAG_W-1:0] am;
        logic [MAG_W-1:0] bm;
        logic [MAG_W-1:0] cm;
    } coef_info_t;

    typedef struct packed {
        coef_info_t        info;
        logic [DISC_W-1:0] dmag;
    } disc_side_t;

    typedef struct packed {
        logic [1:0]          neg;
        logic [STATUS_W-1:0] status;
    } pack_side_t;

endpackage

[rtl/core/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, parallel lanes
// sharing one valid/ready flow; stages collapse bubbles under stall.
// ----------------------------------------------------------------------------
module qrs_div #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [LANES-1:0][NUM_W-1:0]      num,
    input  logic [LANES-1:0][DEN_W-1:0]      den,
    input  logic [SIDE_W-1:0]                side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [LANES-1:0][NUM_W-1:0]      quot,
    output logic [SIDE_W-1:0]                out_side
);

    logic                         valid_reg  [NUM_W];
    logic                         valid_prev [NUM_W];
    logic                         load       [NUM_W+1];
    logic [LANES-1:0][DEN_W-1:0]  rem_reg    [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  rem_prev   [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  rem_next   [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]  nq_reg     [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]  nq_prev    [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]  nq_next    [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  den_reg    [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]  den_prev   [NUM_W];
    logic [SIDE_W-1:0]            side_reg   [NUM_W];
    logic [SIDE_W-1:0]            side_prev  [NUM_W];

    assign load[NUM_W] = out_ready;
    assign in_ready    = load[0];
    assign out_valid   = valid_reg[NUM_W-1];
    assign quot        = nq_reg[NUM_W-1];
    assign out_side    = side_reg[NUM_W-1];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        assign load[s] = ~valid_reg[s] | load[s+1];

        if (s == 0) begin : g_first
            assign valid_prev[s] = in_valid;
            assign rem_prev[s]   = '0;
            assign nq_prev[s]    = num;
            assign den_prev[s]   = den;
            assign side_prev[s]  = side;
        end else begin : g_rest
            assign valid_prev[s] = valid_reg[s-1];
            assign rem_prev[s]   = rem_reg[s-1];
            assign nq_prev[s]    = nq_reg[s-1];
            assign den_prev[s]   = den_reg[s-1];
            assign side_prev[s]  = side_reg[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] shifted;
            logic [DEN_W:0] diff;
            logic           take;

            assign shifted = {rem_prev[s][l], nq_prev[s][l][NUM_W-1]};
            assign diff    = shifted - {1'b0, den_prev[s][l]};
            assign take    = shifted >= {1'b0, den_prev[s][l]};
            assign rem_next[s][l] = take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            assign nq_next[s][l]  = {nq_prev[s][l][NUM_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (load[s])
            begin
                valid_reg[s] <= valid_prev[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                rem_reg[s]  <= rem_next[s];
                nq_reg[s]   <= nq_next[s];
                den_reg[s]  <= den_prev[s];
                side_reg[s] <= side_prev[s];
            end
        end
    end

endmodule

[rtl/core/qrs_isqrt.sv]
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage;
// stages collapse bubbles under stall.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [RAD_W-1:0]      rad,
    input  logic [SIDE_W-1:0]     side,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [RAD_W/2-1:0]    root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int RT_W = RAD_W / 2;

    logic                 valid_reg  [RT_W];
    logic                 valid_prev [RT_W];
    logic                 load       [RT_W+1];
    logic [RAD_W-1:0]     rad_reg    [RT_W];
    logic [RAD_W-1:0]     rad_prev   [RT_W];
    logic [RT_W:0]        rem_reg    [RT_W];
    logic [RT_W:0]        rem_prev   [RT_W];
    logic [RT_W:0]        rem_next   [RT_W];
    logic [RT_W-1:0]      root_reg   [RT_W];
    logic [RT_W-1:0]      root_prev  [RT_W];
    logic [RT_W-1:0]      root_next  [RT_W];
    logic [SIDE_W-1:0]    side_reg   [RT_W];
    logic [SIDE_W-1:0]    side_prev  [RT_W];

    assign load[RT_W] = out_ready;
    assign in_ready   = load[0];
    assign out_valid  = valid_reg[RT_W-1];
    assign root       = root_reg[RT_W-1];
    assign out_side   = side_reg[RT_W-1];

    for (genvar s = 0; s < RT_W; s++) begin : g_stage
        logic [RT_W+2:0] rem_sh;
        logic [RT_W+2:0] trial;
        logic [RT_W+2:0] diff;
        logic            take;

        assign load[s] = ~valid_reg[s] | load[s+1];

        if (s == 0) begin : g_first
            assign valid_prev[s] = in_valid;
            assign rad_prev[s]   = rad;
            assign rem_prev[s]   = '0;
            assign root_prev[s]  = '0;
            assign side_prev[s]  = side;
        end else begin : g_rest
            assign valid_prev[s] = valid_reg[s-1];
            assign rad_prev[s]   = rad_reg[s-1];
            assign rem_prev[s]   = rem_reg[s-1];
            assign root_prev[s]  = root_reg[s-1];
            assign side_prev[s]  = side_reg[s-1];
        end

        assign rem_sh       = {rem_prev[s], rad_prev[s][RAD_W-1 -: 2]};
        assign trial        = {1'b0, root_prev[s], 2'b01};
        assign diff         = rem_sh - trial;
        assign take         = rem_sh >= trial;
        assign rem_next[s]  = take ? diff[RT_W:0] : rem_sh[RT_W:0];
        assign root_next[s] = {root_prev[s][RT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (load[s])
            begin
                valid_reg[s] <= valid_prev[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (load[s])
            begin
                rad_reg[s]  <= {rad_prev[s][RAD_W-3:0], 2'b00};
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                side_reg[s] <= side_prev[s];
            end
        end
    end

endmodule

[rtl/core/quadratic_root_solver.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x*x + b*x + c = 0, Q16.16 coefficients in, Q32.16 roots out.
// Stages are decode/multiply, discriminant, 64-stage divider,
// 33-stage square root, operand setup, 50-stage divider, pack/output register.
// Throughput one request per cycle unless root_ready stalls the pipe; stalled stages hold, empty stages fill.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               coef_valid,
    output logic               coef_ready,
    input  qrs_pkg::qrs_in_t   coef,
    output logic               root_valid,
    input  logic               root_ready,
    output qrs_pkg::qrs_out_t  root
);

    import qrs_pkg::*;

    function automatic logic [ROOT_W:0] pack_root(
        input logic                  neg,
        input logic [DIV2_NUM_W-1:0] q
    );
        logic [DIV2_NUM_W-1:0] limit;
        logic [DIV2_NUM_W-1:0] mag;
        logic                  sat;
        limit = neg ? DIV2_NUM_W'(ROOT_NEG_MAG) : DIV2_NUM_W'(ROOT_POS_MAG);
        sat   = q > limit;
        mag   = sat ? limit : q;
        return {sat, neg ? (-mag[ROOT_W-1:0]) : mag[ROOT_W-1:0]};
    endfunction

    // stage A: decode and products
    logic              a_valid_reg;
    logic              a_load;
    coef_info_t        a_info_reg;
    coef_info_t        a_info_next;
    logic [PROD_W-1:0] a_bsq_reg;
    logic [PROD_W-1:0] a_bsq_next;
    logic [PROD_W-1:0] a_ac_reg;
    logic [PROD_W-1:0] a_ac_next;
    logic [MAG_W-1:0]  raw_a;
    logic [MAG_W-1:0]  raw_b;
    logic [MAG_W-1:0]  raw_c;

    // stage B: discriminant
    logic              b_valid_reg;
    logic              b_load;
    disc_side_t        b_side_reg;
    disc_side_t        b_side_next;
    logic [DISC_W-1:0] four_ac;
    logic [DISC_W-1:0] bsq;

    // divider one and square root
    logic                                div1_ready;
    logic [0:0][DIV1_NUM_W-1:0]          div1_num;
    logic [0:0][DIV1_DEN_W-1:0]          div1_den;
    logic                                div1_valid;
    logic [0:0][DIV1_NUM_W-1:0]          div1_quot;
    logic [$bits(disc_side_t)-1:0]       div1_side;
    disc_side_t                          div1_info;
    logic                                sqrt_ready;
    logic [DISC_W-1:0]                   sqrt_rad;
    logic                                sqrt_valid;
    logic [SQRT_W-1:0]                   sqrt_root;
    logic [$bits(coef_info_t)-1:0]       sqrt_side;

    // stage C: operand setup
    logic                                c_valid_reg;
    logic                                c_load;
    logic [1:0][DIV2_NUM_W-1:0]          c_num_reg;
    logic [1:0][DIV2_NUM_W-1:0]          c_num_next;
    logic [1:0][DIV2_DEN_W-1:0]          c_den_reg;
    logic [1:0][DIV2_DEN_W-1:0]          c_den_next;
    pack_side_t                          c_side_reg;
    pack_side_t                          c_side_next;
    coef_info_t                          s_info;
    logic [DIV2_DEN_W-1:0]               twice_a;
    logic [DIV2_DEN_W-1:0]               t2;
    logic                                tneg;

    // divider two and output
    logic                                div2_ready;
    logic                                div2_valid;
    logic [1:0][DIV2_NUM_W-1:0]          div2_quot;
    logic [$bits(pack_side_t)-1:0]       div2_side;
    pack_side_t                          d_side;
    logic [ROOT_W:0]                     p_first;
    logic [ROOT_W:0]                     p_second;
    logic                                d_load;
    logic                                root_valid_reg;
    qrs_out_t                            root_reg;
    qrs_out_t                            root_next;

    assign a_load     = ~a_valid_reg | b_load;
    assign b_load     = ~b_valid_reg | div1_ready;
    assign c_load     = ~c_valid_reg | div2_ready;
    assign d_load     = ~root_valid_reg | root_ready;
    assign coef_ready = a_load;
    assign root_valid = root_valid_reg;
    assign root       = root_reg;

    assign raw_a = coef.coef_a;
    assign raw_b = coef.coef_b;
    assign raw_c = coef.coef_c;

    always_comb
    begin
        a_info_next.sa = raw_a[COEF_W-1];
        a_info_next.sb = raw_b[COEF_W-1];
        a_info_next.sc = raw_c[COEF_W-1];
        a_info_next.am = a_info_next.sa ? (~raw_a + MAG_W'(1)) : raw_a;
        a_info_next.bm = a_info_next.sb ? (~raw_b + MAG_W'(1)) : raw_b;
        a_info_next.cm = a_info_next.sc ? (~raw_c + MAG_W'(1)) : raw_c;
        if (a_info_next.am == '0)
        begin
            a_info_next.kind = (a_info_next.bm == '0) ? CASE_FAIL : CASE_LINEAR;
        end
        else if (a_info_next.cm == '0)
        begin
            a_info_next.kind = CASE_ZERO;
        end
        else if (a_info_next.bm == '0)
        begin
            a_info_next.kind = CASE_SQRT;
        end
        else
        begin
            a_info_next.kind = CASE_GENERAL;
        end
        a_bsq_next = PROD_W'(a_info_next.bm) * PROD_W'(a_info_next.bm);
        a_ac_next  = PROD_W'(a_info_next.am) * PROD_W'(a_info_next.cm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= coef_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_info_reg <= a_info_next;
            a_bsq_reg  <= a_bsq_next;
            a_ac_reg   <= a_ac_next;
        end
    end

    assign four_ac = {a_ac_reg, 2'b00};
    assign bsq     = DISC_W'(a_bsq_reg);

    always_comb
    begin
        b_side_next.info = a_info_reg;
        b_side_next.dmag = '0;
        if (a_info_reg.kind == CASE_GENERAL)
        begin
            if (a_info_reg.sa != a_info_reg.sc)
            begin
                b_side_next.dmag      = bsq + four_ac;
                b_side_next.info.kind = CASE_DPOS;
            end
            else if (bsq == four_ac)
            begin
                b_side_next.dmag      = bsq;
                b_side_next.info.kind = CASE_DZERO;
            end
            else if (bsq > four_ac)
            begin
                b_side_next.dmag      = bsq - four_ac;
                b_side_next.info.kind = CASE_DPOS;
            end
            else
            begin
                b_side_next.dmag      = four_ac - bsq;
                b_side_next.info.kind = CASE_DNEG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_side_reg <= b_side_next;
        end
    end

    assign div1_num[0] = (b_side_reg.info.kind == CASE_SQRT)
                       ? (DIV1_NUM_W'(b_side_reg.info.cm) << (2 * FRAC_W)) : '0;
    assign div1_den[0] = b_side_reg.info.am;

    qrs_div #(
        .LANES  (1),
        .NUM_W  (DIV1_NUM_W),
        .DEN_W  (DIV1_DEN_W),
        .SIDE_W ($bits(disc_side_t))
    ) u_div_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_ready  (div1_ready),
        .num       (div1_num),
        .den       (div1_den),
        .side      (b_side_reg),
        .out_valid (div1_valid),
        .out_ready (sqrt_ready),
        .quot      (div1_quot),
        .out_side  (div1_side)
    );

    assign div1_info = disc_side_t'(div1_side);
    assign sqrt_rad  = (div1_info.info.kind == CASE_SQRT)
                     ? DISC_W'(div1_quot[0]) : div1_info.dmag;

    qrs_isqrt #(
        .RAD_W  (DISC_W),
        .SIDE_W ($bits(coef_info_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div1_valid),
        .in_ready  (sqrt_ready),
        .rad       (sqrt_rad),
        .side      (div1_info.info),
        .out_valid (sqrt_valid),
        .out_ready (c_load),
        .root      (sqrt_root),
        .out_side  (sqrt_side)
    );

    assign s_info  = coef_info_t'(sqrt_side);
    assign twice_a = DIV2_DEN_W'({s_info.am, 1'b0});
    assign t2      = DIV2_DEN_W'(s_info.bm) + DIV2_DEN_W'(sqrt_root);
    assign tneg    = ~s_info.sb;

    always_comb
    begin
        c_num_next         = '0;
        c_den_next[0]      = DIV2_DEN_W'(1);
        c_den_next[1]      = DIV2_DEN_W'(1);
        c_side_next.neg    = 2'b00;
        c_side_next.status = STATUS_REAL;
        case (s_info.kind)
            CASE_LINEAR:
            begin
                c_num_next[0]   = DIV2_NUM_W'(s_info.cm) << FRAC_W;
                c_num_next[1]   = DIV2_NUM_W'(s_info.cm) << FRAC_W;
                c_den_next[0]   = DIV2_DEN_W'(s_info.bm);
                c_den_next[1]   = DIV2_DEN_W'(s_info.bm);
                c_side_next.neg = {2{s_info.sb == s_info.sc}};
            end
            CASE_ZERO:
            begin
                c_num_next[1]      = DIV2_NUM_W'(s_info.bm) << FRAC_W;
                c_den_next[1]      = DIV2_DEN_W'(s_info.am);
                c_side_next.neg[1] = s_info.sb == s_info.sa;
            end
            CASE_SQRT:
            begin
                c_num_next[1] = DIV2_NUM_W'(sqrt_root);
                if (s_info.sa != s_info.sc)
                begin
                    c_num_next[0]      = DIV2_NUM_W'(sqrt_root);
                    c_side_next.neg[1] = 1'b1;
                end
                else
                begin
                    c_side_next.status = STATUS_COMPLEX;
                end
            end
            CASE_DPOS:
            begin
                c_num_next[0]      = DIV2_NUM_W'(t2) << FRAC_W;
                c_den_next[0]      = twice_a;
                c_side_next.neg[0] = tneg != s_info.sa;
                c_num_next[1]      = DIV2_NUM_W'(s_info.cm) << (FRAC_W + 1);
                c_den_next[1]      = t2;
                c_side_next.neg[1] = s_info.sc != tneg;
            end
            CASE_DZERO:
            begin
                c_num_next[0]   = DIV2_NUM_W'(s_info.bm) << FRAC_W;
                c_num_next[1]   = DIV2_NUM_W'(s_info.bm) << FRAC_W;
                c_den_next[0]   = twice_a;
                c_den_next[1]   = twice_a;
                c_side_next.neg = {2{s_info.sb == s_info.sa}};
            end
            CASE_DNEG:
            begin
                c_num_next[0]      = DIV2_NUM_W'(s_info.bm) << FRAC_W;
                c_den_next[0]      = twice_a;
                c_side_next.neg[0] = s_info.sb == s_info.sa;
                c_num_next[1]      = DIV2_NUM_W'(sqrt_root) << FRAC_W;
                c_den_next[1]      = twice_a;
                c_side_next.status = STATUS_COMPLEX;
            end
            default:
            begin
                c_side_next.status = STATUS_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_load)
        begin
            c_valid_reg <= sqrt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_num_reg  <= c_num_next;
            c_den_reg  <= c_den_next;
            c_side_reg <= c_side_next;
        end
    end

    qrs_div #(
        .LANES  (2),
        .NUM_W  (DIV2_NUM_W),
        .DEN_W  (DIV2_DEN_W),
        .SIDE_W ($bits(pack_side_t))
    ) u_div_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid_reg),
        .in_ready  (div2_ready),
        .num       (c_num_reg),
        .den       (c_den_reg),
        .side      (c_side_reg),
        .out_valid (div2_valid),
        .out_ready (d_load),
        .quot      (div2_quot),
        .out_side  (div2_side)
    );

    assign d_side   = pack_side_t'(div2_side);
    assign p_first  = pack_root(d_side.neg[0], div2_quot[0]);
    assign p_second = pack_root(d_side.neg[1], div2_quot[1]);

    always_comb
    begin
        root_next.root_first  = p_first[ROOT_W-1:0];
        root_next.root_second = p_second[ROOT_W-1:0];
        root_next.root_status = d_side.status;
        root_next.saturated   = p_first[ROOT_W] | p_second[ROOT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (d_load)
        begin
            root_valid_reg <= div2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_load)
        begin
            root_reg <= root_next;
        end
    end

endmodule
